>>> rtl/rcov_pkg.sv
// ----------------------------------------------------------------------------
// rcov_pkg: shared types and codes for rounded rectangle coverage
// Result part codes, configuration register indexes and the control
// bundle passed from the geometry stages to the arc stages.
// ----------------------------------------------------------------------------
package rcov_pkg;

  // Result part codes
  localparam logic [1:0] PART_NONE     = 2'd0;
  localparam logic [1:0] PART_STRAIGHT = 2'd1;
  localparam logic [1:0] PART_ARC      = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECT_LEFT     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECT_TOP      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_RADIUS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_MASK   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_MODE     = 3'd6;

  // Reset values of the shape registers that are not zero
  localparam logic [3:0] CORNER_MASK_RST = 4'hf;
  localparam logic       FILL_MODE_RST   = 1'b1;

  // Per-pixel classification handed to the arc stages
  typedef struct packed {
    logic corner;    // pixel sits in a rounded corner square
    logic straight;  // pixel covered as straight edge or interior
    logic filled;    // filled mode, else outline
  } rcov_ctl_t;

endpackage

>>> rtl/rcov_geom.sv
// ----------------------------------------------------------------------------
// rcov_geom: offset and corner classification stages
// Stage A forms the pixel offsets, the inside test and the clamped radius.
// Stage B folds the offsets toward the nearest corner, classifies the pixel
// and forms the odd distances used by the arc test.
// ----------------------------------------------------------------------------
module rcov_geom #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel beats
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] pixel_x,
  input  logic signed [COORD_BITS-1:0] pixel_y,
  // shape registers
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_top,
  input  logic        [COORD_BITS-1:0] rect_width,
  input  logic        [COORD_BITS-1:0] rect_height,
  input  logic        [COORD_BITS-2:0] corner_radius,
  input  logic        [3:0]            corner_mask,
  input  logic                         fill_mode,
  // toward the arc stages
  output logic                         geo_valid,
  input  logic                         geo_take,
  output rcov_pkg::rcov_ctl_t          geo_ctl,
  output logic        [COORD_BITS-1:0] geo_mag_u,
  output logic        [COORD_BITS-1:0] geo_mag_v,
  output logic        [COORD_BITS-1:0] geo_diam
);
  import rcov_pkg::*;

  localparam int CB = COORD_BITS;

  // Stage A registers
  logic          va_r;
  logic          inside_r;
  logic [CB-1:0] dx_r, dy_r;
  logic [CB-2:0] rad_r;

  // Stage B registers
  logic          vb_r;
  rcov_ctl_t     ctl_r;
  logic [CB-1:0] mag_u_r, mag_v_r, diam_r;

  logic load_a, load_b;

  // A stage loads when empty or when its contents move on
  assign load_b   = !vb_r || geo_take;
  assign load_a   = !va_r || load_b;
  assign in_stall = !load_a;

  // Stage A: offsets, inside test, radius clamp
  logic signed [CB:0] dx_full, dy_full;
  logic               in_x, in_y;
  logic [CB-1:0]      side_min;
  logic [CB-2:0]      half_side, rad_nxt;

  always_comb begin
    dx_full   = {pixel_x[CB-1], pixel_x} - {rect_left[CB-1], rect_left};
    dy_full   = {pixel_y[CB-1], pixel_y} - {rect_top[CB-1], rect_top};
    in_x      = !dx_full[CB] && (dx_full[CB-1:0] < rect_width);
    in_y      = !dy_full[CB] && (dy_full[CB-1:0] < rect_height);
    side_min  = (rect_width < rect_height) ? rect_width : rect_height;
    half_side = side_min[CB-1:1];
    rad_nxt   = (corner_radius < half_side) ? corner_radius : half_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (load_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      inside_r <= in_x && in_y;
      dx_r     <= dx_full[CB-1:0];
      dy_r     <= dy_full[CB-1:0];
      rad_r    <= rad_nxt;
    end
  end

  // Stage B: fold toward the nearest corner and classify
  logic [CB-1:0] rad_ext, a_off, b_off, d_u, d_v;
  logic          near_l, near_t, border, in_square;
  logic [1:0]    corner_idx;
  rcov_ctl_t     ctl_nxt;

  always_comb begin
    rad_ext    = {1'b0, rad_r};
    near_l     = dx_r < rad_ext;
    near_t     = dy_r < rad_ext;
    a_off      = near_l ? dx_r : (rect_width - CB'(1) - dx_r);
    b_off      = near_t ? dy_r : (rect_height - CB'(1) - dy_r);
    border     = (dx_r == '0) || (dx_r == rect_width - CB'(1)) ||
                 (dy_r == '0) || (dy_r == rect_height - CB'(1));
    in_square  = (rad_r != '0) && (corner_mask != 4'h0) &&
                 (a_off < rad_ext) && (b_off < rad_ext);
    corner_idx = {!near_t, !near_l};
    d_u        = rad_ext - a_off;
    d_v        = rad_ext - b_off;

    ctl_nxt.corner   = inside_r && in_square && corner_mask[corner_idx];
    ctl_nxt.straight = inside_r && !ctl_nxt.corner && (fill_mode || border);
    ctl_nxt.filled   = fill_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (load_b) begin
      vb_r <= va_r;
    end
  end

  // |u| = 2(r-a)-1 and |v| = 2(r-b)-1 inside a corner square
  always_ff @(posedge clk) begin
    if (load_b) begin
      ctl_r   <= ctl_nxt;
      mag_u_r <= {d_u[CB-2:0], 1'b1} - CB'(2);
      mag_v_r <= {d_v[CB-2:0], 1'b1} - CB'(2);
      diam_r  <= {rad_r, 1'b0};
    end
  end

  assign geo_valid = vb_r;
  assign geo_ctl   = ctl_r;
  assign geo_mag_u = mag_u_r;
  assign geo_mag_v = mag_v_r;
  assign geo_diam  = diam_r;

endmodule

>>> rtl/rcov_arc.sv
// ----------------------------------------------------------------------------
// rcov_arc: corner arc test and result register
// Stage C squares the odd distances and the outer and inner diameters.
// The result stage sums, compares against both circles and holds the beat.
// ----------------------------------------------------------------------------
module rcov_arc #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // from the geometry stages
  input  logic                  geo_valid,
  output logic                  geo_take,
  input  rcov_pkg::rcov_ctl_t   geo_ctl,
  input  logic [COORD_BITS-1:0] geo_mag_u,
  input  logic [COORD_BITS-1:0] geo_mag_v,
  input  logic [COORD_BITS-1:0] geo_diam,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  covered,
  output logic [1:0]            part
);
  import rcov_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SQ = 2 * COORD_BITS;

  // Stage C registers
  logic          vc_r;
  rcov_ctl_t     ctl_r;
  logic [SQ-1:0] sq_u_r, sq_v_r, outer_r, inner_r;

  // Result registers
  logic          out_valid_r;
  logic          covered_r;
  logic [1:0]    part_r;

  logic load_c, load_out;

  assign load_out = !out_valid_r || !out_stall;
  assign load_c   = !vc_r || load_out;
  assign geo_take = load_c;

  // Stage C: squares
  logic [CB-1:0] diam_in;
  assign diam_in = geo_diam - CB'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (load_c) begin
      vc_r <= geo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      ctl_r   <= geo_ctl;
      sq_u_r  <= geo_mag_u * geo_mag_u;
      sq_v_r  <= geo_mag_v * geo_mag_v;
      outer_r <= geo_diam * geo_diam;
      inner_r <= diam_in * diam_in;
    end
  end

  // Result stage: sum and compare against both circles
  logic [SQ:0] dist_sq;
  logic        arc_hit;
  logic [1:0]  part_nxt;

  always_comb begin
    dist_sq = {1'b0, sq_u_r} + {1'b0, sq_v_r};
    arc_hit = (dist_sq <= {1'b0, outer_r}) &&
              (ctl_r.filled || (dist_sq >= {1'b0, inner_r}));
    if (ctl_r.corner) begin
      part_nxt = arc_hit ? PART_ARC : PART_NONE;
    end else if (ctl_r.straight) begin
      part_nxt = PART_STRAIGHT;
    end else begin
      part_nxt = PART_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      part_r    <= part_nxt;
      covered_r <= (part_nxt != PART_NONE);
    end
  end

  assign out_valid = out_valid_r;
  assign covered   = covered_r;
  assign part      = part_r;

endmodule

>>> rtl/rounded_rect_pixel_coverage.sv
// ----------------------------------------------------------------------------
// rounded_rect_pixel_coverage: pixel coverage of a rounded rectangle
// Takes one pixel coordinate per beat and reports whether the pixel belongs
// to a rectangle with selectively rounded corners, filled or outlined.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock while in_stall is low and returns
// one result per pixel, in order, through four register stages: two
// geometry stages (offsets and radius clamp, then corner folding and
// classification), one squaring stage and the result register. The first
// stage loads at the accepting edge. Each stage holds its own valid bit and
// loads whenever it is empty or its contents move on, so bubbles are
// squeezed out under out_stall and in_stall rises only when all four
// stages are full.
// Shape registers are written through the cfg port at any time (cfg_ready
// is always high) but take effect on pixels in flight, so write them only
// while no pixel is in the pipeline.
// ----------------------------------------------------------------------------
module rounded_rect_pixel_coverage #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_pixel_x,
  input  logic signed [COORD_BITS-1:0]        in_pixel_y,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_covered,
  output logic [1:0]                          out_part,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcov_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);
  import rcov_pkg::*;

  localparam int CB = COORD_BITS;

  // Shape registers
  logic signed [CB-1:0] rect_left_r, rect_top_r;
  logic        [CB-1:0] rect_width_r, rect_height_r;
  logic        [CB-2:0] corner_radius_r;
  logic        [3:0]    corner_mask_r;
  logic                 fill_mode_r;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r     <= '0;
      rect_top_r      <= '0;
      rect_width_r    <= '0;
      rect_height_r   <= '0;
      corner_radius_r <= '0;
      corner_mask_r   <= CORNER_MASK_RST;
      fill_mode_r     <= FILL_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RECT_LEFT:     rect_left_r     <= cfg_data;
        CFG_RECT_TOP:      rect_top_r      <= cfg_data;
        CFG_RECT_WIDTH:    rect_width_r    <= cfg_data;
        CFG_RECT_HEIGHT:   rect_height_r   <= cfg_data;
        CFG_CORNER_RADIUS: corner_radius_r <= cfg_data[CB-2:0];
        CFG_CORNER_MASK:   corner_mask_r   <= cfg_data[3:0];
        CFG_FILL_MODE:     fill_mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Geometry to arc hand-off
  logic          geo_valid, geo_take;
  rcov_ctl_t     geo_ctl;
  logic [CB-1:0] geo_mag_u, geo_mag_v, geo_diam;

  rcov_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_x       (in_pixel_x),
    .pixel_y       (in_pixel_y),
    .rect_left     (rect_left_r),
    .rect_top      (rect_top_r),
    .rect_width    (rect_width_r),
    .rect_height   (rect_height_r),
    .corner_radius (corner_radius_r),
    .corner_mask   (corner_mask_r),
    .fill_mode     (fill_mode_r),
    .geo_valid     (geo_valid),
    .geo_take      (geo_take),
    .geo_ctl       (geo_ctl),
    .geo_mag_u     (geo_mag_u),
    .geo_mag_v     (geo_mag_v),
    .geo_diam      (geo_diam)
  );

  rcov_arc #(
    .COORD_BITS (COORD_BITS)
  ) u_arc (
    .clk       (clk),
    .rst_n     (rst_n),
    .geo_valid (geo_valid),
    .geo_take  (geo_take),
    .geo_ctl   (geo_ctl),
    .geo_mag_u (geo_mag_u),
    .geo_mag_v (geo_mag_v),
    .geo_diam  (geo_diam),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .covered   (out_covered),
    .part      (out_part)
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: rounded rectangle pixel coverage
// Programs a sequence of rectangle shapes through the cfg port while the
// pipeline is empty, streams pixels with random gaps and result stalls,
// and compares each coverage result against a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
  import rcov_pkg::*;

  localparam int COORD_BITS    = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_SHAPES = 28;
  localparam int PIXELS_PER_SHAPE = 58;

  // Index outside the register list; the block ignores writes to it
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;

  // Corner select bits, same order as the corner mask register
  localparam logic [3:0] CORNER_TL = 4'b0001;
  localparam logic [3:0] CORNER_TR = 4'b0010;
  localparam logic [3:0] CORNER_BL = 4'b0100;
  localparam logic [3:0] CORNER_BR = 4'b1000;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic       covered;
    logic [1:0] part;
  } coverage_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic signed [COORD_BITS-1:0]  in_pixel_x = '0;
  logic signed [COORD_BITS-1:0]  in_pixel_y = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic                          out_covered;
  logic [1:0]                    out_part;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index  = '0;
  logic [COORD_BITS-1:0]         cfg_data   = '0;

  // Shadow copy of the shape registers, reset values
  logic signed [COORD_BITS-1:0]  shape_left   = '0;
  logic signed [COORD_BITS-1:0]  shape_top    = '0;
  logic [COORD_BITS-1:0]         shape_width  = '0;
  logic [COORD_BITS-1:0]         shape_height = '0;
  logic [COORD_BITS-2:0]         shape_radius = '0;
  logic [3:0]                    shape_mask   = CORNER_MASK_RST;
  logic                          shape_fill   = FILL_MODE_RST;

  pixel_t    pixel_q[$];
  coverage_t coverage_q[$];

  logic in_gaps_on  = 1'b1;
  logic out_gaps_on = 1'b1;
  int   in_gap_left    = 0;
  int   out_stall_left = 0;
  int   error_count    = 0;
  int   idle_cycles    = 0;
  int   pushed_count   = 0;
  int   answered_count = 0;

  rounded_rect_pixel_coverage #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_covered(out_covered),
    .out_part   (out_part),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coverage of one pixel against the current shape registers
  function automatic coverage_t predict_coverage(input logic signed [COORD_BITS-1:0] px,
                                                 input logic signed [COORD_BITS-1:0] py);
    longint    w, h, dx, dy, half, r, a, b, u, v, s;
    logic      border;
    logic [3:0] corner;
    coverage_t res;
    w  = longint'(shape_width);
    h  = longint'(shape_height);
    dx = longint'(px) - longint'(shape_left);
    dy = longint'(py) - longint'(shape_top);
    res.part = PART_NONE;
    if (w > 0 && h > 0 && dx >= 0 && dx < w && dy >= 0 && dy < h) begin
      half   = ((w < h) ? w : h) / 2;
      r      = (longint'(shape_radius) < half) ? longint'(shape_radius) : half;
      border = (dx == 0) || (dx == w - 1) || (dy == 0) || (dy == h - 1);
      a      = (dx < r) ? dx : w - 1 - dx;
      b      = (dy < r) ? dy : h - 1 - dy;
      corner = 4'b0000;
      if (r > 0 && shape_mask != 4'b0000 && a < r && b < r) begin
        if (dy < r) corner = (dx < r) ? CORNER_TL : CORNER_TR;
        else        corner = (dx < r) ? CORNER_BL : CORNER_BR;
      end
      if ((shape_mask & corner) != 4'b0000) begin
        u = 2 * a - 2 * r + 1;
        v = 2 * b - 2 * r + 1;
        s = u * u + v * v;
        if (s <= 4 * r * r && (shape_fill || s >= 4 * (r - 1) * (r - 1)))
          res.part = PART_ARC;
      end else if (shape_fill || border) begin
        res.part = PART_STRAIGHT;
      end
    end
    res.covered = (res.part != PART_NONE);
    return res;
  endfunction

  // Pixel driver: hold a stalled beat, otherwise advance after any gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        coverage_q.push_back(predict_coverage(in_pixel_x, in_pixel_y));
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          pixel_t pix;
          pix = pixel_q.pop_front();
          in_valid   <= 1'b1;
          in_pixel_x <= pix.x;
          in_pixel_y <= pix.y;
          in_gap_left = in_gaps_on ? draw_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest expectation, drive stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        answered_count++;
        if (coverage_q.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected result: covered=%0d part=%0d", out_covered, out_part);
          error_count++;
        end else begin
          coverage_t exp_cov;
          exp_cov = coverage_q.pop_front();
          if (out_covered !== exp_cov.covered || out_part !== exp_cov.part) begin
            if (error_count < MAX_REPORTS)
              $display("mismatch: expected covered=%0d part=%0d, got covered=%0d part=%0d",
                       exp_cov.covered, exp_cov.part, out_covered, out_part);
            error_count++;
          end
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_stall <= 1'b1;
      end else if (out_gaps_on && $urandom_range(0, 99) < 20) begin
        out_stall_left = draw_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Write one shape register and track it in the shadow copy
  task automatic write_shape_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [COORD_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RECT_LEFT:     shape_left   = data;
      CFG_RECT_TOP:      shape_top    = data;
      CFG_RECT_WIDTH:    shape_width  = data;
      CFG_RECT_HEIGHT:   shape_height = data;
      CFG_CORNER_RADIUS: shape_radius = data[COORD_BITS-2:0];
      CFG_CORNER_MASK:   shape_mask   = data[3:0];
      CFG_FILL_MODE:     shape_fill   = data[0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [COORD_BITS-1:0] left, input logic [COORD_BITS-1:0] top,
                           input logic [COORD_BITS-1:0] w, input logic [COORD_BITS-1:0] h,
                           input logic [COORD_BITS-1:0] rad, input logic [COORD_BITS-1:0] mask,
                           input logic [COORD_BITS-1:0] fill);
    write_shape_reg(CFG_RECT_LEFT, left);
    write_shape_reg(CFG_RECT_TOP, top);
    write_shape_reg(CFG_RECT_WIDTH, w);
    write_shape_reg(CFG_RECT_HEIGHT, h);
    write_shape_reg(CFG_CORNER_RADIUS, rad);
    write_shape_reg(CFG_CORNER_MASK, mask);
    write_shape_reg(CFG_FILL_MODE, fill);
  endtask

  task automatic push_pixel(input longint x, input longint y);
    pixel_t pix;
    pix.x = x[COORD_BITS-1:0];
    pix.y = y[COORD_BITS-1:0];
    pixel_q.push_back(pix);
    pushed_count++;
  endtask

  // Wait until every pixel has been answered, then let the pipeline settle
  task automatic drain();
    while (answered_count != pushed_count)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] extreme_size();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 12'd1;
      2: return 12'd4095;
      default: return COORD_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] extreme_coord();
    case ($urandom_range(0, 2))
      0: return 12'h800;
      1: return 12'h7ff;
      default: return COORD_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // Program a random shape; mostly small rectangles, some extremes
  task automatic random_shape();
    logic [COORD_BITS-1:0] left, top, w, h, rad;
    int roll, half;
    roll = $urandom_range(0, 99);
    left = COORD_BITS'($urandom_range(0, 4095));
    top  = COORD_BITS'($urandom_range(0, 4095));
    if (roll < 8) begin
      left = extreme_coord();
      top  = extreme_coord();
      w    = extreme_size();
      h    = extreme_size();
    end else if (roll < 20) begin
      w = COORD_BITS'($urandom_range(1, 400));
      h = COORD_BITS'($urandom_range(1, 400));
    end else begin
      w = COORD_BITS'($urandom_range(1, 40));
      h = COORD_BITS'($urandom_range(1, 40));
    end
    half = int'(((w < h) ? w : h) / 2);
    roll = $urandom_range(0, 99);
    if (roll < 10)      rad = '0;
    else if (roll < 20) rad = COORD_BITS'($urandom_range(0, 4095));
    else if (roll < 30) rad = 12'd2047;
    else                rad = COORD_BITS'($urandom_range(0, half + 2));
    set_shape(left, top, w, h, rad, COORD_BITS'($urandom_range(0, 4095)),
              COORD_BITS'($urandom_range(0, 4095)));
    if ($urandom_range(0, 4) == 0)
      write_shape_reg(CFG_UNUSED_IDX, COORD_BITS'($urandom_range(0, 4095)));
  endtask

  // Aim pixels at the corner squares and the rectangle border
  task automatic queue_random_pixel();
    longint w, h, r, half, x, y, ox, oy;
    int roll;
    w    = longint'(shape_width);
    h    = longint'(shape_height);
    half = ((w < h) ? w : h) / 2;
    r    = (longint'(shape_radius) < half) ? longint'(shape_radius) : half;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      x = longint'($urandom_range(0, 4095));
      y = longint'($urandom_range(0, 4095));
    end else if (roll < 60 && r > 0) begin
      ox = longint'($urandom_range(0, int'(r) + 1));
      oy = longint'($urandom_range(0, int'(r) + 1));
      x  = $urandom_range(0, 1) ? longint'(shape_left) + ox : longint'(shape_left) + w - 1 - ox;
      y  = $urandom_range(0, 1) ? longint'(shape_top) + oy : longint'(shape_top) + h - 1 - oy;
    end else begin
      x = longint'(shape_left) - 2 + longint'($urandom_range(0, int'(w) + 3));
      y = longint'(shape_top) - 2 + longint'($urandom_range(0, int'(h) + 3));
    end
    push_pixel(x, y);
  endtask

  // Stimulus and end of run
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty rectangle at reset values
    push_pixel(0, 0);
    push_pixel(-2048, -2048);
    push_pixel(2047, 2047);
    push_pixel(-1, 2047);
    drain();

    // Largest rectangle, radius at its clamp limit, filled
    set_shape(12'h800, 12'h800, 12'd4095, 12'd4095, 12'd2047, 12'd15, 12'd1);
    push_pixel(-2048, -2048);
    push_pixel(0, 0);
    push_pixel(2046, 2046);
    push_pixel(2047, 2047);
    drain();

    // Outline with two rounded corners: arc, outside arc, straight edges, square corner
    set_shape(12'd10, 12'd20, 12'd9, 12'd6, 12'd3, 12'd5, 12'd0);
    push_pixel(10, 20);
    push_pixel(11, 20);
    push_pixel(12, 22);
    push_pixel(14, 20);
    push_pixel(14, 22);
    push_pixel(18, 20);
    push_pixel(10, 25);
    drain();

    // Requested radius clamped down to one
    set_shape(-12'sd5, -12'sd5, 12'd3, 12'd3, 12'd5, 12'd15, 12'd1);
    push_pixel(-5, -5);
    push_pixel(-4, -4);
    push_pixel(-3, -5);
    drain();

    // Single-pixel outline
    set_shape(12'd100, 12'd100, 12'd1, 12'd1, 12'd0, 12'd0, 12'd0);
    push_pixel(100, 100);
    push_pixel(101, 100);
    drain();

    // Right edge beyond the coordinate range must not wrap
    set_shape(12'd2000, 12'd0, 12'd4095, 12'd10, 12'd0, 12'd0, 12'd1);
    push_pixel(2047, 5);
    push_pixel(-2048, 5);
    drain();

    // Random shapes, each with its own idle pattern
    for (int shape_idx = 0; shape_idx < RANDOM_SHAPES; shape_idx++) begin
      random_shape();
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (PIXELS_PER_SHAPE) queue_random_pixel();
      drain();
    end

    if (error_count == 0 && coverage_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rcov_pkg.sv
rtl/rcov_geom.sv
rtl/rcov_arc.sv
rtl/rounded_rect_pixel_coverage.sv
tb/testbench.sv
